// File: hw/rtl/gprl_pkg.sv
// Package for the grating period run-length meter.
// Holds widths, register indexes, sequencer states, shared structs and helpers.
// No dependencies.
`default_nettype none

package gprl_pkg;

	localparam int PIXEL_COUNT_BITS = 24;

	localparam int COLOR_W   = 8;
	localparam int LEVEL_W   = 13;
	localparam int PIXSZ_W   = 24;
	localparam int MEAN_W    = 48;
	localparam int TOTAL_W   = 25;
	localparam int COUNT_W   = PIXEL_COUNT_BITS + 1;
	localparam int PROD_W    = COUNT_W + PIXSZ_W;
	localparam int ITER_W    = $clog2(PROD_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = PIXSZ_W;

	localparam int MEAN_CMP_W  = (PROD_W > MEAN_W) ? PROD_W : MEAN_W + 1;
	localparam int TOTAL_CMP_W = (COUNT_W > TOTAL_W) ? COUNT_W : TOTAL_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {1'b1, {PIXEL_COUNT_BITS{1'b0}}};
	localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(PROD_W - 1);

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET  = 13'd3213;
	localparam logic [PIXSZ_W-1:0] PIXEL_SIZE_RESET = 24'd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_HOLD
	} seq_state_t;

	// totals of one image, as they stand after the current pixel
	typedef struct packed {
		logic [COUNT_W-1:0] period_sum;
		logic [COUNT_W-1:0] transition_count;
	} run_tot_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_res_t;

	function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s > {1'b0, COUNT_MAX})
			return COUNT_MAX;
		return s[COUNT_W-1:0];
	endfunction

	function automatic logic [MEAN_W-1:0] clamp_mean(input logic [PROD_W-1:0] q);
		logic [MEAN_CMP_W-1:0] w;
		logic [MEAN_CMP_W-1:0] lim;
		w   = MEAN_CMP_W'(q);
		lim = MEAN_CMP_W'({MEAN_W{1'b1}});
		if (w > lim)
			return {MEAN_W{1'b1}};
		return w[MEAN_W-1:0];
	endfunction

	function automatic logic [TOTAL_W-1:0] clamp_total(input logic [COUNT_W-1:0] c);
		logic [TOTAL_CMP_W-1:0] w;
		logic [TOTAL_CMP_W-1:0] lim;
		w   = TOTAL_CMP_W'(c);
		lim = TOTAL_CMP_W'({TOTAL_W{1'b1}});
		if (w > lim)
			return {TOTAL_W{1'b1}};
		return w[TOTAL_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gprl_runs.sv
// Pixel classifier and run-length counters of the grating period meter.
// Depends on gprl_pkg.
`default_nettype none

module gprl_runs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [gprl_pkg::COLOR_W-1:0] red,
	input  wire logic [gprl_pkg::COLOR_W-1:0] green,
	input  wire logic [gprl_pkg::COLOR_W-1:0] blue,
	input  wire logic                         last_pixel,
	input  wire logic [gprl_pkg::LEVEL_W-1:0] threshold,
	output gprl_pkg::run_tot_t                tot_next
);

	logic [gprl_pkg::COUNT_W-1:0] bright_run_q, dark_run_q;
	logic [gprl_pkg::COUNT_W-1:0] period_sum_q, trans_cnt_q;
	logic [gprl_pkg::COUNT_W-1:0] bright_d, dark_d, sum_mid, sum_d, trans_d;
	logic [9:0]                   rgb_sum;
	logic [13:0]                  level;
	logic                         is_bright, is_dark;

	// level = 10 * (r + g + b), at most 7650
	assign rgb_sum   = 10'(red) + 10'(green) + 10'(blue);
	assign level     = {1'b0, rgb_sum, 3'b000} + {3'b000, rgb_sum, 1'b0};
	assign is_bright = level > {1'b0, threshold};
	assign is_dark   = level < {1'b0, threshold};

	always_comb begin
		if (is_bright) begin
			bright_d = gprl_pkg::sat_add(bright_run_q, gprl_pkg::COUNT_W'(1));
			sum_mid  = period_sum_q;
			trans_d  = trans_cnt_q;
		end else begin
			bright_d = '0;
			sum_mid  = gprl_pkg::sat_add(period_sum_q, bright_run_q);
			trans_d  = (bright_run_q != '0) ?
				gprl_pkg::sat_add(trans_cnt_q, gprl_pkg::COUNT_W'(1)) : trans_cnt_q;
		end
		if (is_dark) begin
			dark_d = gprl_pkg::sat_add(dark_run_q, gprl_pkg::COUNT_W'(1));
			sum_d  = sum_mid;
		end else begin
			dark_d = '0;
			sum_d  = gprl_pkg::sat_add(sum_mid, dark_run_q);
		end
	end

	assign tot_next.period_sum       = sum_d;
	assign tot_next.transition_count = trans_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_run_q <= '0;
			dark_run_q   <= '0;
			period_sum_q <= '0;
			trans_cnt_q  <= '0;
		end else if (step) begin
			if (last_pixel) begin
				// image done: totals are captured by the top level
				bright_run_q <= '0;
				dark_run_q   <= '0;
				period_sum_q <= '0;
				trans_cnt_q  <= '0;
			end else begin
				bright_run_q <= bright_d;
				dark_run_q   <= dark_d;
				period_sum_q <= sum_d;
				trans_cnt_q  <= trans_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/gprl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// A zero divisor passes the dividend through. Depends on gprl_pkg.
`default_nettype none

module gprl_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [gprl_pkg::PROD_W-1:0]  dividend,
	input  wire logic [gprl_pkg::COUNT_W-1:0] divisor,
	output gprl_pkg::div_res_t                res
);

	logic                         busy_q, done_q;
	logic [gprl_pkg::ITER_W-1:0]  iter_q;
	logic [gprl_pkg::PROD_W-1:0]  quo_q;
	logic [gprl_pkg::COUNT_W-1:0] rem_q, divisor_q;
	logic [gprl_pkg::COUNT_W:0]   shifted, trial;
	logic                         fits;

	assign shifted = {rem_q, quo_q[gprl_pkg::PROD_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= (divisor != '0);
				done_q <= (divisor == '0);
				iter_q <= gprl_pkg::ITER_LAST;
			end else if (busy_q) begin
				iter_q <= iter_q - gprl_pkg::ITER_W'(1);
				if (iter_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[gprl_pkg::PROD_W-2:0], fits};
			rem_q <= fits ? trial[gprl_pkg::COUNT_W-1:0] : shifted[gprl_pkg::COUNT_W-1:0];
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

`default_nettype wire

// File: hw/rtl/grating_period_run_length_meter.sv
// Grating period run-length meter, top level: config registers, sequencer, output register.
// Pixels are taken while the sequencer is idle; the last pixel of an image starts the sequence:
// a multiply step, the 49-bit divide (one quotient bit per cycle, skipped with no transitions),
// then an output load that waits for a free output register; input waits until that load.
// Reset (arst_n low) clears counters and output valid and loads threshold 3213, pixel size 1.0.
// Depends on gprl_pkg, gprl_runs and gprl_div.
`default_nettype none

module grating_period_run_length_meter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// pixel channel
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic [gprl_pkg::COLOR_W-1:0]    red,
	input  wire logic [gprl_pkg::COLOR_W-1:0]    green,
	input  wire logic [gprl_pkg::COLOR_W-1:0]    blue,
	input  wire logic                            last_pixel,
	// result channel
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [gprl_pkg::MEAN_W-1:0]     mean_period,
	output      logic [gprl_pkg::TOTAL_W-1:0]    transition_total,
	// configuration writes
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [gprl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gprl_pkg::CFG_DATA_W-1:0] cfg_data
);

	gprl_pkg::seq_state_t state_q, state_d;

	logic [gprl_pkg::LEVEL_W-1:0] threshold_q;
	logic [gprl_pkg::PIXSZ_W-1:0] pixel_size_q;
	logic [gprl_pkg::COUNT_W-1:0] sum_q, trans_q;
	logic [gprl_pkg::PROD_W-1:0]  product;
	logic                         in_xfer, out_xfer;
	logic                         div_start, out_load;
	logic                         out_valid_q;
	logic [gprl_pkg::MEAN_W-1:0]  mean_q;
	logic [gprl_pkg::TOTAL_W-1:0] total_q;

	gprl_pkg::run_tot_t tot_next;
	gprl_pkg::div_res_t div_res;

	assign in_xfer   = in_valid && in_ready;
	assign out_xfer  = out_valid_q && out_ready;
	assign cfg_ready = 1'b1;

	// configuration registers; writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= gprl_pkg::THRESHOLD_RESET;
			pixel_size_q <= gprl_pkg::PIXEL_SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gprl_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data[gprl_pkg::LEVEL_W-1:0];
				gprl_pkg::CFG_PIXEL_SIZE: pixel_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-pixel run tracking
	gprl_runs u_runs (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (in_xfer),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel),
		.threshold  (threshold_q),
		.tot_next   (tot_next)
	);

	// image totals, captured on the last pixel's transfer
	always_ff @(posedge clk) begin
		if (in_xfer && last_pixel) begin
			sum_q   <= tot_next.period_sum;
			trans_q <= tot_next.transition_count;
		end
	end

	// period sum times pixel size; the divider's dividend register holds it
	assign product = gprl_pkg::PROD_W'(sum_q) * gprl_pkg::PROD_W'(pixel_size_q);

	gprl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (trans_q),
		.res      (div_res)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gprl_pkg::ST_IDLE: if (in_xfer && last_pixel) state_d = gprl_pkg::ST_MUL;
			gprl_pkg::ST_MUL:  state_d = gprl_pkg::ST_DIV;
			gprl_pkg::ST_DIV:  if (div_res.done) state_d = gprl_pkg::ST_HOLD;
			gprl_pkg::ST_HOLD: if (!out_valid_q || out_ready) state_d = gprl_pkg::ST_IDLE;
			default:           state_d = gprl_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			gprl_pkg::ST_IDLE: in_ready  = 1'b1;
			gprl_pkg::ST_MUL:  div_start = 1'b1;
			gprl_pkg::ST_DIV:  ;
			gprl_pkg::ST_HOLD: out_load  = !out_valid_q || out_ready;
			default:           ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gprl_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// output register: a waiting result does not block new pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_xfer)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_q  <= gprl_pkg::clamp_mean(div_res.quotient);
			total_q <= gprl_pkg::clamp_total(trans_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign mean_period      = mean_q;
	assign transition_total = total_q;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the grating period run-length meter.
// Predicts every end-of-image result from its own run tracker, checks under random flow control.
// Depends on gprl_pkg and grating_period_run_length_meter.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// run control
	localparam int CYCLE_LIMIT    = 1_000_000;  // slowest legal run stays far below this
	localparam int SEQ_LATENCY    = 60;         // multiply + 49 divide steps + load, with margin
	localparam int RANDOM_PIXELS  = 600;
	localparam int PHASE_PIXELS   = 75;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int MAX_SUM        = 765;        // 3 * 255
	localparam int MAX_REPORTS    = 40;

	// register indexes past the end of the map; writes there must be dropped
	localparam logic [gprl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [gprl_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	localparam logic [63:0] MEAN_LIMIT  = (64'd1 << gprl_pkg::MEAN_W) - 64'd1;
	localparam logic [63:0] TOTAL_LIMIT = (64'd1 << gprl_pkg::TOTAL_W) - 64'd1;

	typedef struct packed {
		logic [gprl_pkg::COLOR_W-1:0] r;
		logic [gprl_pkg::COLOR_W-1:0] g;
		logic [gprl_pkg::COLOR_W-1:0] b;
	} rgb_t;

	typedef struct {
		logic [gprl_pkg::MEAN_W-1:0]  mean;
		logic [gprl_pkg::TOTAL_W-1:0] total;
	} period_result_t;

	// what a pixel should look like relative to the threshold
	typedef enum {
		TONE_BRIGHT,
		TONE_DARK,
		TONE_EQUAL,
		TONE_NOISE
	} tone_t;

	// DUT ports
	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [gprl_pkg::COLOR_W-1:0]    red;
	logic [gprl_pkg::COLOR_W-1:0]    green;
	logic [gprl_pkg::COLOR_W-1:0]    blue;
	logic                            last_pixel;
	logic                            out_valid;
	logic                            out_ready;
	logic [gprl_pkg::MEAN_W-1:0]     mean_period;
	logic [gprl_pkg::TOTAL_W-1:0]    transition_total;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [gprl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gprl_pkg::CFG_DATA_W-1:0] cfg_data;

	// shadow registers and run tracker
	logic [gprl_pkg::LEVEL_W-1:0] thr_model;
	logic [gprl_pkg::PIXSZ_W-1:0] pix_model;
	logic [gprl_pkg::COUNT_W-1:0] bright_len;
	logic [gprl_pkg::COUNT_W-1:0] dark_len;
	logic [gprl_pkg::COUNT_W-1:0] ended_len_sum;
	logic [gprl_pkg::COUNT_W-1:0] bright_ends;

	// results still owed by the block, oldest first
	period_result_t expected_periods[$];

	// flow control shared between stimulus and the result sink
	bit calm_mode;
	int holdoff_request;

	int error_count;
	int pixels_sent;
	int images_predicted;
	int results_checked;
	int cfg_writes;
	int cycle_count;

	grating_period_run_length_meter u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.last_pixel       (last_pixel),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mean_period      (mean_period),
		.transition_total (transition_total),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// run counters stop at 2^PIXEL_COUNT_BITS instead of wrapping
	function automatic logic [gprl_pkg::COUNT_W-1:0] count_add(
			input logic [gprl_pkg::COUNT_W-1:0] a,
			input logic [gprl_pkg::COUNT_W-1:0] b);
		logic [63:0] s;
		s = 64'(a) + 64'(b);
		return (s > 64'(gprl_pkg::COUNT_MAX)) ? gprl_pkg::COUNT_MAX
			: s[gprl_pkg::COUNT_W-1:0];
	endfunction

	// Update the runs for one transferred pixel; on the last pixel of an image
	// queue the result and start the next image from scratch.
	task automatic advance_runs(input rgb_t px, input logic last);
		int             level;
		logic [63:0]    prod;
		logic [63:0]    mean;
		period_result_t res;
		level = 10 * (int'(px.r) + int'(px.g) + int'(px.b));
		// anything not above the threshold closes the bright run
		if (level > int'(thr_model)) begin
			bright_len = count_add(bright_len, gprl_pkg::COUNT_W'(1));
		end else begin
			ended_len_sum = count_add(ended_len_sum, bright_len);
			if (bright_len != '0)
				bright_ends = count_add(bright_ends, gprl_pkg::COUNT_W'(1));
			bright_len = '0;
		end
		// anything not below it closes the dark run; a pixel right at the
		// threshold closes both
		if (level < int'(thr_model)) begin
			dark_len = count_add(dark_len, gprl_pkg::COUNT_W'(1));
		end else begin
			ended_len_sum = count_add(ended_len_sum, dark_len);
			dark_len = '0;
		end
		if (last) begin
			prod = 64'(ended_len_sum) * 64'(pix_model);
			// no transitions: the product goes out undivided
			mean = (bright_ends != '0) ? prod / 64'(bright_ends) : prod;
			res.mean  = (mean > MEAN_LIMIT) ? MEAN_LIMIT[gprl_pkg::MEAN_W-1:0]
				: mean[gprl_pkg::MEAN_W-1:0];
			res.total = (64'(bright_ends) > TOTAL_LIMIT) ? TOTAL_LIMIT[gprl_pkg::TOTAL_W-1:0]
				: bright_ends[gprl_pkg::TOTAL_W-1:0];
			expected_periods.push_back(res);
			images_predicted++;
			// open runs are dropped with the rest of the image
			bright_len    = '0;
			dark_len      = '0;
			ended_len_sum = '0;
			bright_ends   = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Pixel generation
	// ------------------------------------------------------------------

	function automatic rgb_t rgb_of(input int r, input int g, input int b);
		rgb_t px;
		px.r = gprl_pkg::COLOR_W'(r);
		px.g = gprl_pkg::COLOR_W'(g);
		px.b = gprl_pkg::COLOR_W'(b);
		return px;
	endfunction

	// spread a channel sum over three bytes at random
	function automatic rgb_t split_sum(input int s);
		rgb_t px;
		int   lo;
		int   hi;
		int   rest;
		lo = (s > 510) ? s - 510 : 0;
		hi = (s < 255) ? s : 255;
		px.r = gprl_pkg::COLOR_W'($urandom_range(hi, lo));
		rest = s - int'(px.r);
		lo = (rest > 255) ? rest - 255 : 0;
		hi = (rest < 255) ? rest : 255;
		px.g = gprl_pkg::COLOR_W'($urandom_range(hi, lo));
		px.b = gprl_pkg::COLOR_W'(rest - int'(px.g));
		return px;
	endfunction

	// Pixel of the wanted tone under the current threshold. Tones that the
	// threshold makes impossible (e.g. dark at threshold 0) fall back to noise.
	function automatic rgb_t tone_pixel(input tone_t tone);
		int base;
		int top;
		int s;
		bit found;
		base  = int'(thr_model) / 10;
		found = 1'b0;
		s     = 0;
		case (tone)
			TONE_BRIGHT: begin
				if (base < MAX_SUM) begin
					found = 1'b1;
					case ($urandom_range(0, 3))
						0: s = MAX_SUM;
						1: s = base + 1;              // just above
						default: s = $urandom_range(MAX_SUM, base + 1);
					endcase
				end
			end
			TONE_DARK: begin
				if (thr_model != '0) begin
					found = 1'b1;
					top = (int'(thr_model) - 1) / 10;
					if (top > MAX_SUM)
						top = MAX_SUM;
					case ($urandom_range(0, 3))
						0: s = 0;
						1: s = top;                   // just below
						default: s = $urandom_range(top, 0);
					endcase
				end
			end
			TONE_EQUAL: begin
				// only thresholds that are multiples of ten can be hit exactly
				if (int'(thr_model) % 10 == 0 && base <= MAX_SUM) begin
					found = 1'b1;
					s = base;
				end
			end
			default: ;
		endcase
		if (!found)
			return rgb_t'(24'($urandom));
		return split_sum(s);
	endfunction

	function automatic tone_t pick_tone();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return TONE_BRIGHT;
		if (r < 8)
			return TONE_DARK;
		if (r == 8)
			return TONE_EQUAL;
		return TONE_NOISE;
	endfunction

	// mostly short idles, now and then a long one
	function automatic int pick_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic int pick_gap();
		if (calm_mode || $urandom_range(0, 3) != 0)
			return 0;
		return pick_len();
	endfunction

	// mostly small images, a few single pixels and a few long ones
	function automatic int pick_image_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 1;
		if (r == 1)
			return $urandom_range(200, 60);
		return $urandom_range(20, 2);
	endfunction

	// ------------------------------------------------------------------
	// Drivers. All input changes happen at the falling edge; handshakes are
	// sampled at the rising edge. Each task returns right after a falling
	// edge without touching its valid there, so the caller may either hold
	// valid for the next transfer or drop it.
	// ------------------------------------------------------------------

	task automatic send_pixel(input rgb_t px, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		red        <= px.r;
		green      <= px.g;
		blue       <= px.b;
		last_pixel <= last;
		in_valid   <= 1'b1;
		do @(posedge clk); while (!in_ready);
		advance_runs(px, last);
		pixels_sent++;
		@(negedge clk);
	endtask

	// one image built from runs of bright, dark and threshold-level pixels
	task automatic send_image(input int len, input bit noisy);
		tone_t tone;
		int    run_left;
		int    i;
		tone     = TONE_DARK;
		run_left = 0;
		for (i = 0; i < len; i++) begin
			if (run_left == 0) begin
				tone     = noisy ? TONE_NOISE : pick_tone();
				run_left = (tone == TONE_EQUAL) ? $urandom_range(2, 1) : $urandom_range(6, 1);
			end
			send_pixel(tone_pixel(tone), i == len - 1);
			run_left--;
		end
	endtask

	task automatic cfg_write(input logic [gprl_pkg::CFG_IDX_W-1:0] idx,
			input logic [gprl_pkg::CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			gprl_pkg::CFG_THRESHOLD:  thr_model = data[gprl_pkg::LEVEL_W-1:0];
			gprl_pkg::CFG_PIXEL_SIZE: pix_model = data[gprl_pkg::PIXSZ_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
	endtask

	// write both registers; threshold writes sometimes carry junk above bit 12
	task automatic apply_setting(input int thr, input logic [gprl_pkg::PIXSZ_W-1:0] psz);
		logic [gprl_pkg::CFG_DATA_W-1:0] data;
		data = $urandom_range(0, 1) ? gprl_pkg::CFG_DATA_W'($urandom) : '0;
		data[gprl_pkg::LEVEL_W-1:0] = gprl_pkg::LEVEL_W'(thr);
		cfg_write(gprl_pkg::CFG_THRESHOLD, data);
		cfg_write(gprl_pkg::CFG_PIXEL_SIZE, psz);
		cfg_valid <= 1'b0;
	endtask

	// Quiesce before touching registers: every owed result is in, then allow
	// a full divide sequence in case the block is still busy.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_periods.size() != 0)
			@(negedge clk);
		repeat (SEQ_LATENCY) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result sink: random stalls, calm stretches, and a long hold-off on
	// request that is counted down here.
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int hold_left;
		out_ready  = 1'b0;
		stall_left = 0;
		hold_left  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holdoff_request > 0) begin
				hold_left       = holdoff_request;
				holdoff_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm_mode && $urandom_range(0, 4) == 0) begin
				stall_left = pick_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	// compare each result transfer against the oldest prediction
	always @(posedge clk) begin
		period_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_periods.size() == 0) begin
				report_mismatch("unexpected result (mean_period)", 64'd0, 64'(mean_period));
			end else begin
				want = expected_periods.pop_front();
				if (mean_period !== want.mean)
					report_mismatch("mean_period", 64'(want.mean), 64'(mean_period));
				if (transition_total !== want.total)
					report_mismatch("transition_total", 64'(want.total), 64'(transition_total));
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: alternating full-white/black pixels, then a lone pixel
	// that leaves an open bright run (nothing ended, zero transitions).
	task automatic test_reset_defaults();
		send_pixel(rgb_of(255, 255, 255), 1'b0);
		send_pixel(rgb_of(0, 0, 0), 1'b0);
		send_pixel(rgb_of(255, 255, 255), 1'b0);
		send_pixel(rgb_of(0, 0, 0), 1'b1);
		send_pixel(rgb_of(8'h55, 8'hAA, 8'h80), 1'b1);
	endtask

	// Pixels exactly at the threshold end both runs at once.
	task automatic test_equal_level();
		wait_idle();
		apply_setting(3210, gprl_pkg::PIXEL_SIZE_RESET);
		send_pixel(rgb_of(200, 200, 200), 1'b0);
		send_pixel(rgb_of(200, 200, 200), 1'b0);
		send_pixel(rgb_of(107, 107, 107), 1'b0);
		send_pixel(rgb_of(10, 20, 30), 1'b0);
		send_pixel(rgb_of(10, 20, 30), 1'b0);
		send_pixel(rgb_of(100, 110, 111), 1'b0);
		send_pixel(rgb_of(255, 0, 255), 1'b0);
		send_pixel(rgb_of(0, 66, 255), 1'b1);
	endtask

	// A dark run closed without any bright run: product comes out undivided,
	// with the largest pixel size.
	task automatic test_no_transitions();
		wait_idle();
		apply_setting(3210, {gprl_pkg::PIXSZ_W{1'b1}});
		send_pixel(rgb_of(0, 0, 0), 1'b0);
		send_pixel(rgb_of(106, 107, 107), 1'b0);
		send_pixel(rgb_of(1, 0, 0), 1'b0);
		send_pixel(rgb_of(107, 107, 107), 1'b1);
	endtask

	task automatic test_pixel_size_zero();
		wait_idle();
		apply_setting(gprl_pkg::THRESHOLD_RESET, '0);
		send_pixel(rgb_of(255, 255, 255), 1'b0);
		send_pixel(rgb_of(0, 0, 0), 1'b0);
		send_pixel(rgb_of(255, 255, 0), 1'b1);
	endtask

	// writes past the register map must leave both registers alone
	task automatic test_unused_index();
		wait_idle();
		cfg_write(gprl_pkg::CFG_THRESHOLD, gprl_pkg::CFG_DATA_W'(gprl_pkg::THRESHOLD_RESET));
		cfg_write(gprl_pkg::CFG_PIXEL_SIZE, gprl_pkg::PIXEL_SIZE_RESET);
		cfg_write(CFG_UNUSED_A, gprl_pkg::CFG_DATA_W'($urandom));
		cfg_write(CFG_UNUSED_B, gprl_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		send_pixel(rgb_of(255, 255, 255), 1'b0);
		send_pixel(rgb_of(0, 0, 0), 1'b0);
		send_pixel(rgb_of(255, 255, 255), 1'b0);
		send_pixel(rgb_of(0, 0, 0), 1'b1);
	endtask

	// Result sink holds off for a long stretch while images keep coming, so
	// the output register fills and the pixel input must stall.
	task automatic test_output_hold_off();
		int i;
		holdoff_request = HOLDOFF_CYCLES;
		for (i = 0; i < 8; i++)
			send_image($urandom_range(5, 3), 1'b0);
	endtask

	// Random images over a sweep of settings: reset values, a threshold that
	// equal-level pixels can hit, both threshold extremes, the level where
	// nothing is bright, pixel size zero/one/max, then random settings.
	task automatic test_random_images();
		int                           phase;
		int                           phase_start;
		int                           pix_start;
		int                           thr;
		logic [gprl_pkg::PIXSZ_W-1:0] psz;
		phase     = 0;
		pix_start = pixels_sent;
		while (pixels_sent - pix_start < RANDOM_PIXELS) begin
			case (phase)
				0: begin
					thr = gprl_pkg::THRESHOLD_RESET;
					psz = gprl_pkg::PIXEL_SIZE_RESET;
				end
				1: begin thr = 3210; psz = gprl_pkg::PIXEL_SIZE_RESET; end
				2: begin thr = 0;    psz = {gprl_pkg::PIXSZ_W{1'b1}};  end
				3: begin thr = 8191; psz = gprl_pkg::PIXSZ_W'(1);      end
				4: begin thr = 7650; psz = '0;                         end
				5: begin
					thr = 10 * $urandom_range(MAX_SUM, 0);
					psz = gprl_pkg::PIXSZ_W'($urandom);
				end
				6: begin thr = 3840; psz = gprl_pkg::PIXSZ_W'($urandom); end
				default: begin
					thr = ($urandom_range(0, 1) != 0) ? 10 * $urandom_range(MAX_SUM, 0)
						: $urandom_range(8191, 0);
					psz = gprl_pkg::PIXSZ_W'($urandom);
				end
			endcase
			phase++;
			wait_idle();
			apply_setting(thr, psz);
			phase_start = pixels_sent;
			while (pixels_sent - phase_start < PHASE_PIXELS) begin
				// some images run with no idling on either side
				calm_mode = ($urandom_range(0, 4) == 0);
				send_image(pick_image_len(), $urandom_range(0, 7) == 0);
			end
			calm_mode = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		red             = '0;
		green           = '0;
		blue            = '0;
		last_pixel      = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = gprl_pkg::CFG_THRESHOLD;
		cfg_data        = '0;
		calm_mode       = 1'b0;
		holdoff_request = 0;
		thr_model       = gprl_pkg::THRESHOLD_RESET;
		pix_model       = gprl_pkg::PIXEL_SIZE_RESET;
		bright_len      = '0;
		dark_len        = '0;
		ended_len_sum   = '0;
		bright_ends     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_equal_level();
		test_no_transitions();
		test_pixel_size_zero();
		test_unused_index();
		test_output_hold_off();
		test_random_images();

		// drain: everything owed has arrived, then watch for stragglers
		wait_idle();

		$display("Covered %0d pixels, %0d images (%0d results checked), %0d register writes.",
			pixels_sent, images_predicted, results_checked, cfg_writes);
		$display("Thresholds 0..8191 with equal-level pixels, pixel sizes 0..max, %0d-cycle stall.",
			HOLDOFF_CYCLES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles", CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// File: grating_period_run_length_meter.f
hw/rtl/gprl_pkg.sv
hw/rtl/gprl_runs.sv
hw/rtl/gprl_div.sv
hw/rtl/grating_period_run_length_meter.sv
tb/sv/tb_top.sv
